// ===== src/tkf_pkg.sv =====
package tkf_pkg;

    localparam int HEAP_DEPTH = 16;
    localparam int ADDR_W     = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int LVL_W      = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W      = ADDR_W + 2;
    localparam int WORD_W     = 32;
    localparam int KEEP_W     = 5;
    localparam int ENTRY_W    = 2 * WORD_W;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Keep count with zero taken as one and large values clipped to the heap depth.
    function automatic logic [LVL_W-1:0] eff_keep(input logic [KEEP_W-1:0] k);
        logic [LVL_W-1:0] res;
        if (k == '0) begin
            res = LVL_W'(1);
        end else if (int'(k) > HEAP_DEPTH) begin
            res = LVL_W'(HEAP_DEPTH);
        end else begin
            res = LVL_W'(k);
        end
        return res;
    endfunction

endpackage

// ===== src/tkf_ram.sv =====
module tkf_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 64,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tkf_ctrl.sv =====
module tkf_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_action,
    input  logic [tkf_pkg::WORD_W-1:0] i_word_id,
    input  logic [tkf_pkg::WORD_W-1:0] i_word_count,
    input  logic [tkf_pkg::LVL_W-1:0]  i_keep_eff,
    input  tkf_pkg::t_entry            i_rdata,
    output tkf_pkg::t_ram_req          o_req,
    output logic                       o_busy,
    output logic                       o_strobe,
    output logic [tkf_pkg::WORD_W-1:0] o_held_word,
    output logic [tkf_pkg::WORD_W-1:0] o_held_count,
    output logic                       o_last_entry,
    output logic                       o_heap_empty
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_CHK = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_RT_CMP = 3'd3;
    localparam logic [2:0] S_DN_CHK = 3'd4;
    localparam logic [2:0] S_DN_L   = 3'd5;
    localparam logic [2:0] S_DN_R   = 3'd6;
    localparam logic [2:0] S_RD_OUT = 3'd7;

    localparam int AW = tkf_pkg::ADDR_W;
    localparam int LW = tkf_pkg::LVL_W;
    localparam int XW = tkf_pkg::IDX_W;

    localparam int WORD_W_LOCAL = tkf_pkg::WORD_W;

    logic [2:0]      r_state, n_state;
    logic [LW-1:0]   r_fill, n_fill;
    logic [AW-1:0]   r_pos, n_pos;
    tkf_pkg::t_entry r_item, n_item;
    tkf_pkg::t_entry r_cand, n_cand;
    logic            r_cand_ok, n_cand_ok;
    logic            r_out_valid, n_out_valid;
    tkf_pkg::t_entry r_out, n_out;
    logic            r_last, n_last;
    logic            r_empty, n_empty;

    logic [AW-1:0]   parent;
    logic [XW-1:0]   left_x, right_x, fill_x;
    logic            win_ok;
    tkf_pkg::t_entry win_entry;
    logic [AW-1:0]   win_idx;
    logic [WORD_W_LOCAL-1:0] min_count;
    logic            rd_last;

    assign parent  = AW'((r_pos - AW'(1)) >> 1);
    assign left_x  = XW'({r_pos, 1'b1});
    assign right_x = left_x + XW'(1);
    assign fill_x  = XW'(r_fill);
    assign rd_last = (LW'(r_pos) + LW'(1)) == r_fill;

    // Pick the child that moves up, if any. The left child wins a tie between children.
    always_comb begin
        min_count = r_cand_ok ? r_cand.count : r_item.count;
        win_ok    = 1'b0;
        win_entry = i_rdata;
        win_idx   = AW'(left_x);
        if (r_state == S_DN_R) begin
            if (i_rdata.count < min_count) begin
                win_ok  = 1'b1;
                win_idx = AW'(right_x);
            end else if (r_cand_ok) begin
                win_ok    = 1'b1;
                win_entry = r_cand;
            end
        end else begin
            win_ok = i_rdata.count < r_item.count;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_item      = r_item;
        n_cand      = r_cand;
        n_cand_ok   = r_cand_ok;
        n_out_valid = 1'b0;
        n_out       = r_out;
        n_last      = r_last;
        n_empty     = r_empty;
        o_req.we    = 1'b0;
        o_req.waddr = r_pos;
        o_req.wdata = r_item;
        o_req.raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == tkf_pkg::ACT_READ) begin
                        if (r_fill == '0) begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_last      = 1'b0;
                            n_empty     = 1'b1;
                        end else begin
                            n_pos   = '0;
                            n_state = S_RD_OUT;
                        end
                    end else begin
                        n_item.word  = i_word_id;
                        n_item.count = i_word_count;
                        if (r_fill < i_keep_eff) begin
                            n_pos   = AW'(r_fill);
                            n_fill  = r_fill + LW'(1);
                            n_state = S_UP_CHK;
                        end else begin
                            n_state = S_RT_CMP;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                if (r_pos == '0) begin
                    o_req.we = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_req.raddr = parent;
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_req.we = 1'b1;
                if (r_item.count < i_rdata.count) begin
                    o_req.wdata = i_rdata;
                    n_pos       = parent;
                    n_state     = S_UP_CHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RT_CMP: begin
                if (r_item.count > i_rdata.count) begin
                    n_pos   = '0;
                    n_state = S_DN_CHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DN_CHK: begin
                if (left_x >= fill_x) begin
                    o_req.we = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_req.raddr = AW'(left_x);
                    n_state     = S_DN_L;
                end
            end
            S_DN_L, S_DN_R: begin
                n_cand    = i_rdata;
                n_cand_ok = i_rdata.count < r_item.count;
                if (r_state == S_DN_L && right_x < fill_x) begin
                    o_req.raddr = AW'(right_x);
                    n_state     = S_DN_R;
                end else if (win_ok) begin
                    o_req.we    = 1'b1;
                    o_req.wdata = win_entry;
                    n_pos       = win_idx;
                    n_state     = S_DN_CHK;
                end else begin
                    o_req.we = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_RD_OUT: begin
                n_out_valid = 1'b1;
                n_out       = i_rdata;
                n_last      = rd_last;
                n_empty     = 1'b0;
                if (rd_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_pos       = r_pos + AW'(1);
                    o_req.raddr = r_pos + AW'(1);
                end
            end
        endcase

        if (r_state == S_IDLE && i_start && i_action == tkf_pkg::ACT_OFFER
            && !(r_fill < i_keep_eff)) begin
            o_req.raddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_pos     <= n_pos;
        r_item    <= n_item;
        r_cand    <= n_cand;
        r_cand_ok <= n_cand_ok;
        r_out     <= n_out;
        r_last    <= n_last;
        r_empty   <= n_empty;
    end

    assign o_busy       = r_state != S_IDLE;
    assign o_strobe     = r_out_valid;
    assign o_held_word  = r_out.word;
    assign o_held_count = r_out.count;
    assign o_last_entry = r_last;
    assign o_heap_empty = r_empty;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= tkf_pkg::HEAP_DEPTH)
        else $error("fill level beyond heap depth");

    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_fill >= $past(r_fill))
        else $error("fill level dropped without reset");

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($past(r_state) == S_RD_OUT || $past(i_start)))
        else $error("result strobe without a read-out");

    a_empty_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_empty) |-> (r_fill == '0 && !r_last))
        else $error("empty result while entries are held");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> r_state == S_IDLE)
        else $error("block still busy after the last entry");

endmodule

// ===== src/top_k_frequency_select.sv =====
// Top-k frequency selector. The block keeps the keep_count most frequent
// words of a stream of (word id, count) offers in a min-heap ordered by
// count, stored in one dual-port RAM with a registered read data output.
// Pulse start with i_action low to offer a word: while fewer than the
// keep count entries are held the word is appended and sifted up, and
// afterwards it replaces the root only when its count is strictly greater
// than the root's, and is then sifted down. An offer produces no result
// word. Pulse start with i_action high to read out: every held entry comes
// out in heap array order, one word per cycle on o_strobe, with
// o_last_entry set on the final one; an empty heap gives a single word
// with o_heap_empty set and all other fields zero. The receiver cannot
// hold results off, so every strobed word must be taken in that cycle.
// The single RAM read port sets the pace. An appended offer reads and
// compares each parent in turn on its way up, and the word is written
// where it stops. A replacing offer first reads the root and ends there
// when it does not beat it; otherwise each level descended reads the left
// child and, where present, the right child; the word is written where no
// child beats it. A read-out is busy while it reads its entries; an empty
// read-out gives its word without ever raising busy.
// busy is high while an item is in progress and start is ignored then.
// keep_count may only be written while busy is low and no strobe is due.
// Reset clears the fill level; the RAM itself needs no clearing because
// only entries below the fill level are ever read.
module top_k_frequency_select (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_action,
    input  logic [tkf_pkg::WORD_W-1:0]         i_word_id,
    input  logic [tkf_pkg::WORD_W-1:0]         i_word_count,
    input  logic                               i_keep_we,
    input  logic [tkf_pkg::KEEP_W-1:0]         i_keep_count,
    output logic                               o_strobe,
    output logic [tkf_pkg::WORD_W-1:0]         o_held_word,
    output logic [tkf_pkg::WORD_W-1:0]         o_held_count,
    output logic                               o_last_entry,
    output logic                               o_heap_empty
);

    // Keep count register, clipped to a usable value before use.
    logic [tkf_pkg::KEEP_W-1:0] r_keep;
    logic [tkf_pkg::LVL_W-1:0]  keep_eff;

    tkf_pkg::t_ram_req ram_req;
    tkf_pkg::t_entry   ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= tkf_pkg::KEEP_RESET;
        end else if (i_keep_we) begin
            r_keep <= i_keep_count;
        end
    end

    assign keep_eff = tkf_pkg::eff_keep(r_keep);

    // Heap storage: one entry holds the word id and its count.
    tkf_ram #(
        .DEPTH  (tkf_pkg::HEAP_DEPTH),
        .DATA_W (tkf_pkg::ENTRY_W),
        .ADDR_W (tkf_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer for sift up, sift down and read-out.
    tkf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_action     (i_action),
        .i_word_id    (i_word_id),
        .i_word_count (i_word_count),
        .i_keep_eff   (keep_eff),
        .i_rdata      (ram_rdata),
        .o_req        (ram_req),
        .o_busy       (busy),
        .o_strobe     (o_strobe),
        .o_held_word  (o_held_word),
        .o_held_count (o_held_count),
        .o_last_entry (o_last_entry),
        .o_heap_empty (o_heap_empty)
    );

endmodule

// ===== tb/tkf_result_checker.sv =====
`timescale 1ns / 100ps

module tkf_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic                       i_action,
    input  logic [tkf_pkg::WORD_W-1:0] i_word_id,
    input  logic [tkf_pkg::WORD_W-1:0] i_word_count,
    input  logic                       i_keep_we,
    input  logic [tkf_pkg::KEEP_W-1:0] i_keep_count,
    input  logic                       i_strobe,
    input  logic [tkf_pkg::WORD_W-1:0] i_held_word,
    input  logic [tkf_pkg::WORD_W-1:0] i_held_count,
    input  logic                       i_last_entry,
    input  logic                       i_heap_empty,
    output int                         o_mismatches,
    output int                         o_outstanding
);

    typedef struct packed {
        logic [tkf_pkg::WORD_W-1:0] held_id;
        logic [tkf_pkg::WORD_W-1:0] held_cnt;
        logic                       is_last;
        logic                       is_empty;
    } t_held_rec;

    // Private copy of the heap, its fill level and the keep register.
    logic [tkf_pkg::WORD_W-1:0] heap_id_m  [tkf_pkg::HEAP_DEPTH];
    logic [tkf_pkg::WORD_W-1:0] heap_cnt_m [tkf_pkg::HEAP_DEPTH];
    int                         held_n;
    logic [tkf_pkg::KEEP_W-1:0] keep_reg;
    t_held_rec                  readout_q [$];
    int                         mismatches;

    assign o_mismatches = mismatches;

    initial begin
        mismatches    = 0;
        held_n        = 0;
        keep_reg      = tkf_pkg::KEEP_RESET;
        o_outstanding = 0;
    end

    task automatic report_mismatch(input string what,
                                   input logic [tkf_pkg::WORD_W-1:0] got,
                                   input logic [tkf_pkg::WORD_W-1:0] want);
        $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int keep_limit();
        int k;
        k = int'(keep_reg);
        if (k == 0) k = 1;
        if (k > tkf_pkg::HEAP_DEPTH) k = tkf_pkg::HEAP_DEPTH;
        return k;
    endfunction

    function automatic void swap_slots(input int a, input int b);
        logic [tkf_pkg::WORD_W-1:0] tid;
        logic [tkf_pkg::WORD_W-1:0] tcnt;
        tid           = heap_id_m[a];
        tcnt          = heap_cnt_m[a];
        heap_id_m[a]  = heap_id_m[b];
        heap_cnt_m[a] = heap_cnt_m[b];
        heap_id_m[b]  = tid;
        heap_cnt_m[b] = tcnt;
    endfunction

    // Append-and-climb while filling, replace-root-and-descend once full.
    function automatic void apply_offer(input logic [tkf_pkg::WORD_W-1:0] w,
                                        input logic [tkf_pkg::WORD_W-1:0] c);
        int pos;
        int parent;
        int least;
        int left;
        int right;
        if (held_n < keep_limit()) begin
            heap_id_m[held_n]  = w;
            heap_cnt_m[held_n] = c;
            pos    = held_n;
            held_n = held_n + 1;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (heap_cnt_m[pos] < heap_cnt_m[parent]) begin
                    swap_slots(pos, parent);
                    pos = parent;
                end else begin
                    break;
                end
            end
        end else if (held_n > 0 && c > heap_cnt_m[0]) begin
            heap_id_m[0]  = w;
            heap_cnt_m[0] = c;
            pos = 0;
            while (1) begin
                least = pos;
                left  = 2 * pos + 1;
                right = 2 * pos + 2;
                if (left < held_n && heap_cnt_m[left] < heap_cnt_m[least]) least = left;
                if (right < held_n && heap_cnt_m[right] < heap_cnt_m[least]) least = right;
                if (least == pos) break;
                swap_slots(pos, least);
                pos = least;
            end
        end
    endfunction

    function automatic void queue_readout();
        t_held_rec rec;
        if (held_n == 0) begin
            rec = '{held_id: '0, held_cnt: '0, is_last: 1'b0, is_empty: 1'b1};
            readout_q.insert(readout_q.size(), rec);
        end else begin
            for (int i = 0; i < held_n; i++) begin
                rec.held_id  = heap_id_m[i];
                rec.held_cnt = heap_cnt_m[i];
                rec.is_last  = (i == held_n - 1);
                rec.is_empty = 1'b0;
                readout_q.insert(readout_q.size(), rec);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_held_rec want;
        if (!i_rst_n) begin
            held_n   = 0;
            keep_reg = tkf_pkg::KEEP_RESET;
            readout_q.delete();
        end else begin
            if (i_strobe) begin
                if (readout_q.size() == 0) begin
                    report_mismatch("unexpected held_word", i_held_word, '0);
                end else begin
                    want = readout_q.pop_front();
                    if (i_held_word !== want.held_id)
                        report_mismatch("held_word", i_held_word, want.held_id);
                    if (i_held_count !== want.held_cnt)
                        report_mismatch("held_count", i_held_count, want.held_cnt);
                    if (i_last_entry !== want.is_last)
                        report_mismatch("last_entry", tkf_pkg::WORD_W'(i_last_entry),
                                        tkf_pkg::WORD_W'(want.is_last));
                    if (i_heap_empty !== want.is_empty)
                        report_mismatch("heap_empty", tkf_pkg::WORD_W'(i_heap_empty),
                                        tkf_pkg::WORD_W'(want.is_empty));
                end
            end
            // An item accepted at this edge still sees the old keep value.
            if (i_start && !i_busy) begin
                if (i_action == tkf_pkg::ACT_OFFER) apply_offer(i_word_id, i_word_count);
                else queue_readout();
            end
            if (i_keep_we) keep_reg = i_keep_count;
        end
        o_outstanding <= readout_q.size();
    end

endmodule

// ===== tb/tb_top_k_frequency_select.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the top-k frequency selector. The checker beside
// the block predicts every read-out and compares each strobed word; this
// module only feeds items, writes the keep register between phases and
// decides the outcome from the checker's mismatch count.
module tb_top_k_frequency_select;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       start        = 1'b0;
    logic                       busy;
    logic                       i_action     = tkf_pkg::ACT_OFFER;
    logic [tkf_pkg::WORD_W-1:0] i_word_id    = '0;
    logic [tkf_pkg::WORD_W-1:0] i_word_count = '0;
    logic                       i_keep_we    = 1'b0;
    logic [tkf_pkg::KEEP_W-1:0] i_keep_count = '0;
    logic                       o_strobe;
    logic [tkf_pkg::WORD_W-1:0] o_held_word;
    logic [tkf_pkg::WORD_W-1:0] o_held_count;
    logic                       o_last_entry;
    logic                       o_heap_empty;

    int mismatches;
    int outstanding;

    // Sender pacing: a word stays offered back to back while a burst lasts.
    int burst_left = 0;
    bit start_held = 1'b0;

    // Keep settings of the random phases. The heap only fills during the
    // first three of them; after that every offer goes through the root
    // rule, and the out-of-range values still exercise zero and saturation
    // handling.
    int unsigned keep_plan [9] = '{8, 12, 31, 17, 16, 5, 1, 0, 16};

    always #4 i_clk = ~i_clk;

    top_k_frequency_select DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_word_id    (i_word_id),
        .i_word_count (i_word_count),
        .i_keep_we    (i_keep_we),
        .i_keep_count (i_keep_count),
        .o_strobe     (o_strobe),
        .o_held_word  (o_held_word),
        .o_held_count (o_held_count),
        .o_last_entry (o_last_entry),
        .o_heap_empty (o_heap_empty)
    );

    tkf_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_action      (i_action),
        .i_word_id     (i_word_id),
        .i_word_count  (i_word_count),
        .i_keep_we     (i_keep_we),
        .i_keep_count  (i_keep_count),
        .i_strobe      (o_strobe),
        .i_held_word   (o_held_word),
        .i_held_count  (o_held_count),
        .i_last_entry  (o_last_entry),
        .i_heap_empty  (o_heap_empty),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Offers one word and waits for the edge that accepts it. Values read
    // right after the edge are the ones the block saw at that edge. When
    // the burst goes on, start is left high so the next call just swaps
    // the fields in; otherwise the sender drops start and idles a while.
    task automatic send_word(input logic act, input logic [tkf_pkg::WORD_W-1:0] w,
                             input logic [tkf_pkg::WORD_W-1:0] c);
        start        <= 1'b1;
        i_action     <= act;
        i_word_id    <= w;
        i_word_count <= c;
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
            start_held = 1'b1;
        end else begin
            start      <= 1'b0;
            start_held = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Waits until the block is idle and every predicted word has arrived.
    // An offer gives no word, so the trailing cycles cover the longest
    // sift that may still be running.
    task automatic settle();
        if (start_held) start <= 1'b0;
        start_held = 1'b0;
        do @(posedge i_clk); while (busy || outstanding != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_keep(input logic [tkf_pkg::KEEP_W-1:0] value);
        settle();
        i_keep_we    <= 1'b1;
        i_keep_count <= value;
        @(posedge i_clk);
        i_keep_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Counts mix the extremes, a narrow band near the top where ties are
    // common among held entries, small values that tie during filling, and
    // the full range.
    function automatic logic [tkf_pkg::WORD_W-1:0] pick_count();
        case ($urandom_range(0, 19))
            0, 1:          return '0;
            2:             return '1;
            3, 4, 5, 6, 7,
            8, 9:          return 32'hFFFF_FF00 + $urandom_range(0, 255);
            10, 11, 12, 13: return $urandom();
            default:       return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [tkf_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A read-out right after reset finds the heap empty.
        send_word(tkf_pkg::ACT_READ, '1, '1);

        // Keep one: equal count is refused, a larger one takes the root.
        write_keep(tkf_pkg::KEEP_W'(1));
        send_word(tkf_pkg::ACT_OFFER, '0, 32'd5);
        send_word(tkf_pkg::ACT_OFFER, '1, 32'd5);
        send_word(tkf_pkg::ACT_OFFER, 32'hA5A5_A5A5, 32'd6);
        send_word(tkf_pkg::ACT_READ, '0, '0);

        // Keep zero behaves as keep one.
        write_keep(tkf_pkg::KEEP_W'(0));
        send_word(tkf_pkg::ACT_OFFER, 32'h5A5A_5A5A, '0);
        send_word(tkf_pkg::ACT_OFFER, '1, '1);
        send_word(tkf_pkg::ACT_READ, 32'h1234_5678, 32'h8765_4321);

        // Keep four: ties on the way up must not move a child.
        write_keep(tkf_pkg::KEEP_W'(4));
        send_word(tkf_pkg::ACT_OFFER, 32'd1, 32'd7);
        send_word(tkf_pkg::ACT_OFFER, 32'd2, 32'd7);
        send_word(tkf_pkg::ACT_OFFER, 32'd3, 32'd3);
        send_word(tkf_pkg::ACT_READ, '0, '0);

        // Keep lowered below the fill level: nothing is dropped and
        // offers go through the root, with tied children on the way down.
        write_keep(tkf_pkg::KEEP_W'(2));
        send_word(tkf_pkg::ACT_OFFER, 32'd5, 32'd7);
        send_word(tkf_pkg::ACT_OFFER, 32'd6, 32'd7);
        send_word(tkf_pkg::ACT_OFFER, 32'd7, 32'd2);
        send_word(tkf_pkg::ACT_READ, '0, '0);

        // Random phases, mostly offers with a read-out now and then.
        foreach (keep_plan[p]) begin
            write_keep(tkf_pkg::KEEP_W'(keep_plan[p]));
            for (int i = 0; i < 51; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_word(tkf_pkg::ACT_READ, $urandom(), $urandom());
                end else begin
                    send_word(tkf_pkg::ACT_OFFER, pick_word(), pick_count());
                end
                // Now and then the sender holds off until every read-out
                // word has come back.
                if ($urandom_range(0, 39) == 0) settle();
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout set far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
